FILE: hw/rtl/pia_pkg.sv
// Package for the pooled index allocator: field widths, status and command codes,
// the classified request type, state machine encodings and pool reset sizes.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package pia_pkg;

  localparam int unsigned NumPoolsDef  = 8;
  localparam int unsigned PoolDepthDef = 2048;
  localparam int unsigned NumSizeRegs  = 8;
  localparam int unsigned IndexW       = 12;
  localparam int unsigned SizeW        = 12;
  localparam int unsigned PoolSelW     = 3;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CmdFifoDepth = 2;

  localparam logic [SizeW-1:0] SizeReset [NumSizeRegs] = '{
    12'd2, 12'd1, 12'd2000, 12'd100, 12'd1, 12'd500, 12'd500, 12'd500
  };

  typedef enum logic [StatusW-1:0] {
    ST_GRANTED  = 3'd0,
    ST_ACTIVE   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RETURNED = 3'd3,
    ST_IGNORED  = 3'd4
  } status_e;

  typedef enum logic {
    OP_ALLOC  = 1'b0,
    OP_RETURN = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_RETURN,
    CMD_REJ_ALLOC,
    CMD_REJ_RETURN
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [PoolSelW-1:0] pool;
    logic                idx_ok;
    logic [IndexW-1:0]   index;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_EVAL
  } back_state_e;

  typedef enum logic [1:0] {
    CLR_IDLE,
    CLR_ALL,
    CLR_POOL
  } clr_state_e;

  // Size a pool takes after reset; pools without a size register are empty.
  function automatic logic [SizeW-1:0] reset_size(int unsigned p);
    if (p < NumSizeRegs) begin
      return SizeReset[p[CfgIdxW-1:0]];
    end
    return '0;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pia_front.sv
// Front end of the pooled index allocator: accepts requests and classifies them.
// Depends on pia_pkg; feeds pia_cmd_fifo.
`timescale 1ns / 1ps
`default_nettype none

module pia_front #(
  parameter int unsigned NUM_POOLS  = pia_pkg::NumPoolsDef,
  parameter int unsigned POOL_DEPTH = pia_pkg::PoolDepthDef
) (
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          operation_i,
  input  wire logic [pia_pkg::PoolSelW-1:0]  pool_select_i,
  input  wire logic signed [pia_pkg::IndexW-1:0] index_in_i,
  input  wire logic                          clearing_i,
  input  wire logic                          fifo_full_i,
  output logic                               push_o,
  output pia_pkg::cmd_t                      cmd_o
);
  import pia_pkg::*;

  logic pool_ok;
  logic idx_ok;

  // A negative index or one past the pool depth can never be active.
  assign pool_ok = 32'(pool_select_i) < NUM_POOLS;
  assign idx_ok  = !index_in_i[IndexW-1] && (32'(index_in_i[IndexW-2:0]) < POOL_DEPTH);

  always_comb begin
    cmd_o.pool   = pool_select_i;
    cmd_o.idx_ok = idx_ok;
    cmd_o.index  = index_in_i;
    priority if (!pool_ok) begin
      cmd_o.kind = (operation_i == OP_RETURN) ? CMD_REJ_RETURN : CMD_REJ_ALLOC;
    end else if (operation_i == OP_RETURN) begin
      cmd_o.kind = idx_ok ? CMD_RETURN : CMD_REJ_RETURN;
    end else begin
      cmd_o.kind = CMD_ALLOC;
    end
  end

  assign in_ready_o = !fifo_full_i && !clearing_i;
  assign push_o     = in_valid_i && in_ready_o;

endmodule

`default_nettype wire

FILE: hw/rtl/pia_cmd_fifo.sv
// Short queue of classified requests between front and back end.
// Depends on pia_pkg for the request type and queue depth.
`timescale 1ns / 1ps
`default_nettype none

module pia_cmd_fifo (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire pia_pkg::cmd_t cmd_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         empty_o,
  output pia_pkg::cmd_t cmd_o
);
  import pia_pkg::*;

  localparam int unsigned PtrW = $clog2(CmdFifoDepth);
  localparam int unsigned CntW = $clog2(CmdFifoDepth + 1);

  cmd_t            entry_q [CmdFifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = count_q == CntW'(CmdFifoDepth);
  assign empty_o = count_q == '0;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CmdFifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CmdFifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pia_back.sv
// Back end of the pooled index allocator: queue and mark memories, per-pool
// pointers, the clearing sweep, configuration handling and the result register.
// Depends on pia_pkg; takes requests from pia_cmd_fifo.
`timescale 1ns / 1ps
`default_nettype none

module pia_back #(
  parameter int unsigned NUM_POOLS  = pia_pkg::NumPoolsDef,
  parameter int unsigned POOL_DEPTH = pia_pkg::PoolDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pia_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [pia_pkg::SizeW-1:0]     cfg_data_i,
  input  wire logic                          fifo_empty_i,
  input  wire pia_pkg::cmd_t                 fifo_cmd_i,
  output logic                               fifo_pop_o,
  output logic                               clearing_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [pia_pkg::IndexW-1:0]  index_out_o,
  output logic [pia_pkg::StatusW-1:0]        status_o
);
  import pia_pkg::*;

  localparam int unsigned IdxW     = $clog2(POOL_DEPTH);
  localparam int unsigned PoolW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int unsigned AddrW    = PoolW + IdxW;
  localparam int unsigned MemDepth = NUM_POOLS << IdxW;
  localparam int unsigned CntW     = $clog2(POOL_DEPTH + 1);
  localparam logic [AddrW-1:0] LastAll   = AddrW'(MemDepth - 1);
  localparam logic [IdxW-1:0]  LastIdx   = {IdxW{1'b1}};
  localparam logic [IdxW-1:0]  LastPtr   = IdxW'(POOL_DEPTH - 1);
  localparam logic [CntW-1:0]  DepthFill = CntW'(POOL_DEPTH);

  function automatic logic [CntW-1:0] clamp_size(logic [SizeW-1:0] v);
    if (32'(v) > POOL_DEPTH) begin
      return DepthFill;
    end
    return CntW'(v);
  endfunction

  function automatic logic [IdxW-1:0] tail_of(logic [CntW-1:0] fill);
    return (fill == DepthFill) ? '0 : IdxW'(fill);
  endfunction

  function automatic logic [IdxW-1:0] advance(logic [IdxW-1:0] ptr);
    return (ptr == LastPtr) ? '0 : ptr + IdxW'(1);
  endfunction

  // Memories.
  logic [IdxW-1:0] store_mem [MemDepth];
  logic            mark_mem  [MemDepth];

  // Per-pool queue pointers.
  logic [IdxW-1:0] head_q [NUM_POOLS];
  logic [IdxW-1:0] head_d [NUM_POOLS];
  logic [IdxW-1:0] tail_q [NUM_POOLS];
  logic [IdxW-1:0] tail_d [NUM_POOLS];
  logic [CntW-1:0] fill_q [NUM_POOLS];
  logic [CntW-1:0] fill_d [NUM_POOLS];

  back_state_e     bk_state_q, bk_state_d;
  clr_state_e      clr_state_q, clr_state_d;
  logic [AddrW-1:0] clr_cnt_q;
  logic [PoolW-1:0] clr_pool_q;

  cmd_t            cmd_q;
  logic            mark_rd_q;
  logic [IdxW-1:0] store_rd_q;

  logic            out_valid_q;
  logic [IndexW-1:0] out_index_q;
  status_e         out_status_q;

  logic             cfg_we, cfg_pool_ok;
  logic [PoolW-1:0] cfg_pool;
  logic [CntW-1:0]  cfg_fill;

  logic             issue, commit, out_free;
  logic [PoolW-1:0] f_pool, e_pool;
  logic [IdxW-1:0]  f_idx, e_idx;
  logic [AddrW-1:0] mark_rd_addr, store_rd_addr;

  logic             take, give;
  logic             mark_we_e, store_we_e;
  logic [AddrW-1:0] mark_wa_e, store_wa_e;
  logic             mark_wd_e;
  logic [IdxW-1:0]  store_wd_e;
  logic [IndexW-1:0] res_index;
  status_e          res_status;

  logic             clr_we;
  logic [AddrW-1:0] clr_addr;
  logic             mark_we, store_we;
  logic [AddrW-1:0] mark_wa, store_wa;
  logic             mark_wd;
  logic [IdxW-1:0]  store_wd;

  // Configuration.
  assign cfg_ready_o = clr_state_q != CLR_POOL;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_pool_ok = 32'(cfg_index_i) < NUM_POOLS;
  assign cfg_pool    = PoolW'(cfg_index_i);
  assign cfg_fill    = clamp_size(cfg_data_i);
  assign clearing_o  = clr_state_q != CLR_IDLE;

  // Issue: read both memories for the request at the head of the queue.
  assign issue      = (bk_state_q == BK_IDLE) && !fifo_empty_i && !clearing_o;
  assign fifo_pop_o = issue;
  assign f_pool     = (fifo_cmd_i.kind == CMD_ALLOC || fifo_cmd_i.kind == CMD_RETURN)
                      ? PoolW'(fifo_cmd_i.pool) : '0;
  assign f_idx      = fifo_cmd_i.idx_ok ? IdxW'(fifo_cmd_i.index[IndexW-2:0]) : '0;
  assign mark_rd_addr  = {f_pool, f_idx};
  assign store_rd_addr = {f_pool, head_q[f_pool]};

  // Evaluation of the request whose memory data has been read.
  assign out_free = !out_valid_q || out_ready_i;
  assign commit   = (bk_state_q == BK_EVAL) && out_free;
  assign e_pool   = (cmd_q.kind == CMD_ALLOC || cmd_q.kind == CMD_RETURN)
                    ? PoolW'(cmd_q.pool) : '0;
  assign e_idx    = cmd_q.idx_ok ? IdxW'(cmd_q.index[IndexW-2:0]) : '0;

  always_comb begin
    bk_state_d = bk_state_q;
    unique case (bk_state_q)
      BK_IDLE: if (issue) begin
        bk_state_d = BK_EVAL;
      end
      BK_EVAL: if (commit) begin
        bk_state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    res_index  = cmd_q.index;
    res_status = ST_IGNORED;
    take       = 1'b0;
    give       = 1'b0;
    mark_we_e  = 1'b0;
    mark_wa_e  = {e_pool, e_idx};
    mark_wd_e  = 1'b0;
    store_we_e = 1'b0;
    store_wa_e = {e_pool, tail_q[e_pool]};
    store_wd_e = e_idx;
    unique case (cmd_q.kind)
      CMD_REJ_ALLOC: begin
        res_status = ST_EMPTY;
      end
      CMD_REJ_RETURN: begin
        res_status = ST_IGNORED;
      end
      CMD_ALLOC: begin
        priority if (cmd_q.idx_ok && mark_rd_q) begin
          res_status = ST_ACTIVE;
        end else if (fill_q[e_pool] == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_status = ST_GRANTED;
          res_index  = IndexW'(store_rd_q);
          take       = 1'b1;
          mark_we_e  = 1'b1;
          mark_wa_e  = {e_pool, store_rd_q};
          mark_wd_e  = 1'b1;
        end
      end
      CMD_RETURN: begin
        if (mark_rd_q) begin
          res_status = ST_RETURNED;
          mark_we_e  = 1'b1;
          // A full queue drops the push; the mark is still cleared.
          if (fill_q[e_pool] < DepthFill) begin
            give       = 1'b1;
            store_we_e = 1'b1;
          end
        end
      end
    endcase
  end

  // Per-pool pointer updates.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (commit && take) begin
      head_d[e_pool] = advance(head_q[e_pool]);
      fill_d[e_pool] = fill_q[e_pool] - CntW'(1);
    end
    if (commit && give) begin
      tail_d[e_pool] = advance(tail_q[e_pool]);
      fill_d[e_pool] = fill_q[e_pool] + CntW'(1);
    end
    if (cfg_we && cfg_pool_ok) begin
      head_d[cfg_pool] = '0;
      fill_d[cfg_pool] = cfg_fill;
      tail_d[cfg_pool] = tail_of(cfg_fill);
    end
  end

  // Clearing sweep: all pools after reset, one pool after its size is written.
  always_comb begin
    clr_state_d = clr_state_q;
    unique case (clr_state_q)
      CLR_IDLE: if (cfg_we && cfg_pool_ok) begin
        clr_state_d = CLR_POOL;
      end
      CLR_ALL: if (clr_cnt_q == LastAll) begin
        clr_state_d = CLR_IDLE;
      end
      CLR_POOL: if (clr_cnt_q[IdxW-1:0] == LastIdx) begin
        clr_state_d = CLR_IDLE;
      end
      default: clr_state_d = CLR_IDLE;
    endcase
  end

  always_comb begin
    clr_we   = clr_state_q != CLR_IDLE;
    clr_addr = (clr_state_q == CLR_ALL) ? clr_cnt_q : {clr_pool_q, clr_cnt_q[IdxW-1:0]};
  end

  // Memory write ports.
  assign mark_we  = clr_we || (commit && mark_we_e);
  assign mark_wa  = clr_we ? clr_addr : mark_wa_e;
  assign mark_wd  = clr_we ? 1'b0 : mark_wd_e;
  assign store_we = clr_we || (commit && store_we_e);
  assign store_wa = clr_we ? clr_addr : store_wa_e;
  assign store_wd = clr_we ? clr_addr[IdxW-1:0] : store_wd_e;

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    if (issue) begin
      mark_rd_q <= mark_mem[mark_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_wa] <= store_wd;
    end
    if (issue) begin
      store_rd_q <= store_mem[store_rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bk_state_q  <= BK_IDLE;
      clr_state_q <= CLR_ALL;
      clr_cnt_q   <= '0;
      clr_pool_q  <= '0;
      out_valid_q <= 1'b0;
      for (int p = 0; p < NUM_POOLS; p++) begin
        head_q[p] <= '0;
        fill_q[p] <= clamp_size(reset_size(p));
        tail_q[p] <= tail_of(clamp_size(reset_size(p)));
      end
    end else begin
      bk_state_q  <= bk_state_d;
      clr_state_q <= clr_state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      if (clr_state_q == CLR_IDLE) begin
        clr_cnt_q  <= '0;
        clr_pool_q <= cfg_pool;
      end else begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      cmd_q <= fifo_cmd_i;
    end
    if (commit) begin
      out_index_q  <= res_index;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign index_out_o = out_index_q;
  assign status_o    = out_status_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pooled_index_allocator.sv
// Top level of the pooled index allocator: front end, request queue, back end.
// Depends on pia_pkg, pia_front, pia_cmd_fifo and pia_back.
//
// Usage: the block keeps NUM_POOLS index pools, each a first-in first-out
// queue of free indices with one active mark per index. A request on the
// in channel (in_valid_i / in_ready_o) carries an operation, a pool select
// and the index the caller holds. Allocate returns the held index if it is
// already active, else the oldest free index, or the held index with an
// empty status. Return frees an active index and queues it again.
// One result leaves on the out channel (out_valid_o / out_ready_i) per
// request, in request order. The back end first reads the mark and queue
// memories, then decides and writes back once its result register is
// free; it issues no new request before that. The front end keeps
// accepting into a two-entry request queue while a result waits, and the
// back end holds its result register until the receiver takes it.
// After reset a clearing sweep initializes both memories, one entry per
// cycle over NUM_POOLS << clog2(POOL_DEPTH) entries (16384 by default); requests
// wait until it ends, size writes are taken during it. Writing a pool size
// reinitializes that pool by a sweep of its 1 << clog2(POOL_DEPTH) entries,
// during which in_ready_o and cfg_ready_o are low.
`timescale 1ns / 1ps
`default_nettype none

module pooled_index_allocator #(
  parameter int unsigned NUM_POOLS  = pia_pkg::NumPoolsDef,
  parameter int unsigned POOL_DEPTH = pia_pkg::PoolDepthDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              operation_i,
  input  wire logic [pia_pkg::PoolSelW-1:0]      pool_select_i,
  input  wire logic signed [pia_pkg::IndexW-1:0] index_in_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [pia_pkg::IndexW-1:0]      index_out_o,
  output logic [pia_pkg::StatusW-1:0]            status_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [pia_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [pia_pkg::SizeW-1:0]         cfg_data_i
);
  import pia_pkg::*;

  // Requests from the front end enter the queue; the back end drains it.
  logic push, pop, fifo_full, fifo_empty, clearing;
  cmd_t front_cmd, head_cmd;

  pia_front #(
    .NUM_POOLS (NUM_POOLS),
    .POOL_DEPTH(POOL_DEPTH)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .pool_select_i(pool_select_i),
    .index_in_i   (index_in_i),
    .clearing_i   (clearing),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  pia_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .full_o (fifo_full),
    .pop_i  (pop),
    .empty_o(fifo_empty),
    .cmd_o  (head_cmd)
  );

  pia_back #(
    .NUM_POOLS (NUM_POOLS),
    .POOL_DEPTH(POOL_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fifo_empty_i(fifo_empty),
    .fifo_cmd_i  (head_cmd),
    .fifo_pop_o  (pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .index_out_o (index_out_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Testbench for pooled_index_allocator: random and directed allocate and return requests,
// checked against an in-bench model of the free queues and active marks.
// Depends on pia_pkg and the pooled_index_allocator RTL.
`timescale 1ns / 1ps

module tb;
  import pia_pkg::*;

  localparam int unsigned NumPools   = NumPoolsDef;
  localparam int unsigned PoolDepth  = PoolDepthDef;
  localparam int unsigned SlotW      = $clog2(PoolDepth);
  // The reset sweep, 24 size writes and about 450 requests finish well within
  // the limit even with every stall; the limit leaves ample margin.
  localparam int unsigned CycleLimit = 500000;

  typedef struct {
    op_e                      op;
    logic [PoolSelW-1:0]      pool;
    logic signed [IndexW-1:0] held;
  } request_t;

  typedef struct {
    logic signed [IndexW-1:0] index;
    status_e                  status;
  } answer_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       operation_i = 1'b0;
  logic [PoolSelW-1:0]        pool_select_i = '0;
  logic signed [IndexW-1:0]   index_in_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [IndexW-1:0]   index_out_o;
  logic [StatusW-1:0]         status_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CfgIdxW-1:0]         cfg_index_i = '0;
  logic [SizeW-1:0]           cfg_data_i = '0;

  pooled_index_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .pool_select_i (pool_select_i),
    .index_in_i    (index_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .index_out_o   (index_out_o),
    .status_o      (status_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Requests waiting to be offered, and the answers the pools should give,
  // oldest first.
  request_t    pending_requests[$];
  answer_t     expected_answers[$];
  int unsigned mismatches = 0;
  int unsigned answers_seen = 0;
  int unsigned cycle_count = 0;
  bit          request_taken = 1'b0;
  // While set, neither side inserts random idle cycles.
  bit          steady = 1'b0;

  // Model of the pools: size registers, per-pool circular free queues with
  // their pointers and fill counts, and one active mark per index.
  logic [SizeW-1:0] size_reg [NumSizeRegs];
  logic [SlotW-1:0] free_store [NumPools][PoolDepth];
  int unsigned      q_head [NumPools];
  int unsigned      q_tail [NumPools];
  int unsigned      q_fill [NumPools];
  bit               active [NumPools][PoolDepth];

  // Refill one pool: its queue holds 0..size-1 in order and nothing is active.
  // A size above the pool depth is clipped to the depth.
  task automatic refill_pool(input int unsigned p);
    int unsigned s;
    s = (p < NumSizeRegs) ? int'(size_reg[p]) : 0;
    if (s > PoolDepth) begin
      s = PoolDepth;
    end
    for (int unsigned i = 0; i < PoolDepth; i++) begin
      free_store[p][i] = SlotW'(i);
      active[p][i] = 1'b0;
    end
    q_head[p] = 0;
    q_tail[p] = s % PoolDepth;
    q_fill[p] = s;
  endtask

  // Work out the answer to one request and update the pool it addresses.
  task automatic resolve_request(input request_t req, output answer_t ans);
    int          idx;
    int unsigned slot;
    bit          is_active;
    idx = req.held;
    is_active = 1'b0;
    // Negative indices (the empty marker -1 among them) are never active.
    if (idx >= 0 && idx < int'(PoolDepth)) begin
      is_active = active[req.pool][idx];
    end
    ans.index = req.held;
    if (req.op == OP_ALLOC) begin
      if (is_active) begin
        ans.status = ST_ACTIVE;
      end else if (q_fill[req.pool] == 0) begin
        ans.status = ST_EMPTY;
      end else begin
        slot = free_store[req.pool][q_head[req.pool]];
        q_head[req.pool] = (q_head[req.pool] + 1) % PoolDepth;
        q_fill[req.pool]--;
        active[req.pool][slot] = 1'b1;
        ans.index = IndexW'(slot);
        ans.status = ST_GRANTED;
      end
    end else if (!is_active) begin
      ans.status = ST_IGNORED;
    end else begin
      active[req.pool][idx] = 1'b0;
      // A full queue cannot take the push; the mark is cleared regardless.
      if (q_fill[req.pool] < PoolDepth) begin
        free_store[req.pool][q_tail[req.pool]] = SlotW'(idx);
        q_tail[req.pool] = (q_tail[req.pool] + 1) % PoolDepth;
        q_fill[req.pool]++;
      end
      ans.status = ST_RETURNED;
    end
  endtask

  // Sampling at the rising edge: results are checked first so that a request
  // accepted at the same edge cannot hide an unexpected result. Accepted
  // requests and size writes then update the model.
  always @(posedge clk_i) begin : observe
    answer_t  ans;
    request_t req;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        answers_seen++;
        if (expected_answers.size() == 0) begin
          $error("result with no request pending: index_out %0d status %0d",
                 index_out_o, status_o);
          mismatches++;
        end else begin
          ans = expected_answers.pop_front();
          if (index_out_o !== ans.index) begin
            $error("index_out expected %0d actual %0d", ans.index, index_out_o);
            mismatches++;
          end
          if (status_o !== ans.status) begin
            $error("status expected %0d actual %0d", ans.status, status_o);
            mismatches++;
          end
        end
      end
      request_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        req.op = op_e'(operation_i);
        req.pool = pool_select_i;
        req.held = index_in_i;
        resolve_request(req, ans);
        expected_answers.insert(expected_answers.size(), ans);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        size_reg[cfg_index_i] = cfg_data_i;
        if (cfg_index_i < NumPools) begin
          refill_pool(cfg_index_i);
        end
      end
    end
  end

  // Request driver. A new request, or an idle cycle, is chosen only when the
  // channel is free: nothing offered, or the last offer was taken at the
  // preceding edge. An offer otherwise stays up unchanged.
  always @(negedge clk_i) begin : drive_requests
    request_t req;
    if (rst_ni && (!in_valid_i || request_taken)) begin
      if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
        req = pending_requests.pop_front();
        in_valid_i <= 1'b1;
        operation_i <= req.op;
        pool_select_i <= req.pool;
        index_in_i <= req.held;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver. Once, a while into the run, it refuses results for a
  // long stretch so that the request queue inside the block fills and the
  // sender sees in_ready_o drop.
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (!hold_done && answers_seen >= 60) begin
      hold_left = 150;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("pooled_index_allocator test failed");
      $finish;
    end
  end

  task automatic queue_request(input op_e op, input int unsigned pool, input int held);
    request_t req;
    req.op = op;
    req.pool = PoolSelW'(pool);
    req.held = IndexW'(held);
    pending_requests.insert(pending_requests.size(), req);
  endtask

  // Wait until every request has been offered, taken and answered. Every
  // request yields one result, so an empty expectation queue means the block
  // is idle; a short pause covers the back end settling.
  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid_i || expected_answers.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_pool_size(input int unsigned pool, input int unsigned value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgIdxW'(pool);
    cfg_data_i <= SizeW'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned sizes [NumSizeRegs];
    int unsigned span;
    int unsigned pick;
    int unsigned pool;
    op_e         op;
    int          held;

    for (int unsigned p = 0; p < NumSizeRegs; p++) begin
      size_reg[p] = SizeReset[p];
    end
    for (int unsigned p = 0; p < NumPools; p++) begin
      refill_pool(p);
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at the reset sizes (2, 1, 2000, 100, 1, 500, 500, 500).
    // Pool 1 holds a single index: grant it, find the pool empty, ask again
    // with the index held, return it twice, and return the empty marker.
    queue_request(OP_ALLOC, 1, -1);
    queue_request(OP_ALLOC, 1, -1);
    queue_request(OP_ALLOC, 1, 0);
    queue_request(OP_RETURN, 1, 0);
    queue_request(OP_RETURN, 1, 0);
    queue_request(OP_RETURN, 1, -1);
    // The most negative index is out of range: a fresh grant, and a return
    // of it is ignored.
    queue_request(OP_ALLOC, 1, -2048);
    queue_request(OP_RETURN, 1, -2048);
    // A returned index goes to the tail, so pool 0 grants 0, 1, 0 here.
    queue_request(OP_ALLOC, 0, -1);
    queue_request(OP_RETURN, 0, 0);
    queue_request(OP_ALLOC, 0, -1);
    queue_request(OP_ALLOC, 0, -1);
    queue_request(OP_ALLOC, 0, 1365);
    // The largest index is in range but not active.
    queue_request(OP_ALLOC, 2, 2047);
    queue_request(OP_RETURN, 2, 2047);
    queue_request(OP_ALLOC, 3, -1);
    queue_request(OP_ALLOC, 4, -1);
    queue_request(OP_ALLOC, 5, -1);
    queue_request(OP_ALLOC, 6, 682);
    queue_request(OP_ALLOC, 7, -1);
    queue_request(OP_RETURN, 7, 0);
    queue_request(OP_RETURN, 4, 0);
    wait_drained();

    // Random phases. Pools are kept small so they run dry and refill often;
    // the middle phase carries the extremes: a full-depth pool, a size above
    // the depth and an empty pool. The last phase runs with no idling.
    for (int phase = 1; phase <= 3; phase++) begin
      for (int unsigned p = 0; p < NumSizeRegs; p++) begin
        sizes[p] = $urandom_range(6, 1);
      end
      if (phase == 1) begin
        sizes[5] = 0;
      end else if (phase == 2) begin
        sizes[0] = PoolDepth;
        sizes[1] = 4095;
        sizes[2] = 0;
        sizes[3] = 1;
      end else begin
        sizes[4] = 2047;
        steady = 1'b1;
      end
      for (int unsigned p = 0; p < NumSizeRegs; p++) begin
        write_pool_size(p, sizes[p]);
      end

      // Held indices are mostly drawn from the low indices a pool hands out,
      // so returns and repeated allocates usually hit active entries; the
      // rest are the empty marker or fully random values.
      repeat (145) begin
        op = ($urandom_range(99) < 55) ? OP_ALLOC : OP_RETURN;
        pool = $urandom_range(NumPools - 1);
        span = (sizes[pool] == 0) ? 4 : ((sizes[pool] > 12) ? 12 : sizes[pool]);
        pick = $urandom_range(99);
        if (pick < 10) begin
          held = $signed(IndexW'($urandom));
        end else if (pick < 15 || (op == OP_ALLOC && pick < 55)) begin
          held = -1;
        end else begin
          held = $urandom_range(span - 1);
        end
        queue_request(op, pool, held);
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("pooled_index_allocator test passed");
    end else begin
      $display("pooled_index_allocator test failed");
    end
    $finish;
  end

endmodule
